@@ src/pli_pkg.sv @@
// package for the positional list block: word types, status codes, cell control
// no dependencies
package pli_pkg;

  localparam int CNT_W = 7;
  localparam int IDX_W = 6;
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]             action;
    logic [CNT_W-1:0]       position;
    logic signed [VAL_W-1:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] entry_value;
    logic [IDX_W-1:0]        entry_index;
    logic [CNT_W-1:0]        entry_count;
    logic                    last;
  } out_word_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t                op;
    logic [CNT_W-1:0]        slot;      // 0-based insert/delete slot
    logic [CNT_W-1:0]        tail;      // index of last held entry
    logic signed [VAL_W-1:0] new_value;
  } cell_ctl_t;

endpackage

@@ src/pli_cell.sv @@
// one entry of the list chain: holds a value, loads from a neighbor on shifts
// depends on pli_pkg
module pli_cell (
  input  logic                            clk,
  input  pli_pkg::cell_ctl_t              ctl,
  input  logic [pli_pkg::CNT_W-1:0]       cell_idx,
  input  logic signed [pli_pkg::VAL_W-1:0] left_val,
  input  logic signed [pli_pkg::VAL_W-1:0] right_val,
  input  logic signed [pli_pkg::VAL_W-1:0] head_val,
  output logic signed [pli_pkg::VAL_W-1:0] value
);

  logic signed [pli_pkg::VAL_W-1:0] value_r;
  logic signed [pli_pkg::VAL_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    unique case (ctl.op)
      pli_pkg::CELL_INSERT: begin
        if (cell_idx == ctl.slot) begin
          value_nxt = ctl.new_value;
        end else if (cell_idx > ctl.slot) begin
          value_nxt = left_val;
        end
      end
      pli_pkg::CELL_DELETE: begin
        if (cell_idx >= ctl.slot) begin
          value_nxt = right_val;
        end
      end
      // circular shift within the held entries, head wraps to the tail
      pli_pkg::CELL_ROTATE: begin
        if (cell_idx == ctl.tail) begin
          value_nxt = head_val;
        end else if (cell_idx < ctl.tail) begin
          value_nxt = right_val;
        end
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

@@ src/positional_list_insert_delete.sv @@
// top level of the positional list: control sequencer and chain of entry cells
// depends on pli_pkg and pli_cell
//
// Usage:
//   An input word (in_item) is taken at a rising edge with start high and busy
//   low. Insert and delete shift the chain entries from the given position on and
//   give one result word in the cycle after acceptance; busy stays low, so a new
//   word can be issued every cycle. Read-out gives one result per held entry on
//   consecutive cycles, the first after the read state and the output register,
//   with last set on the final entry; busy is high while read-out runs. The chain
//   rotates one place per cycle through the held entries and is back in order when
//   read-out ends. Reading an empty list gives one result with status empty.
//   Action code 3 is dropped without a result.
//   Each result sits on out_result for exactly one cycle, marked by out_valid;
//   the receiver has no way to stall it.
//   Reset (rst_n low, synchronous) empties the list and clears the sequencer;
//   the entry values themselves are not cleared.
module positional_list_insert_delete #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pli_pkg::in_word_t  in_item,
  output logic               out_valid,
  output pli_pkg::out_word_t out_result
);

  localparam logic [pli_pkg::CNT_W-1:0] DEPTH_C = pli_pkg::CNT_W'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t                       state_r, state_nxt;
  logic [pli_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [pli_pkg::IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  pli_pkg::out_word_t           out_r, out_nxt;
  pli_pkg::cell_ctl_t           ctl;

  logic signed [pli_pkg::VAL_W-1:0] cell_val [DEPTH];
  logic [pli_pkg::CNT_W-1:0]        tail;
  logic                             accept;
  logic                             rd_last;

  assign accept  = start && (state_r == S_IDLE);
  assign tail    = count_r - 1'b1;
  assign rd_last = ({1'b0, rd_idx_r} == tail);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    out_nxt.last  = 1'b1;
    ctl.op        = pli_pkg::CELL_HOLD;
    ctl.slot      = in_item.position - 1'b1;
    ctl.tail      = tail;
    ctl.new_value = in_item.item_value;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_item.action)
            pli_pkg::ACT_INSERT: begin
              out_valid_nxt = 1'b1;
              priority if (count_r >= DEPTH_C) begin
                out_nxt.status = pli_pkg::ST_FULL;
              end else if (in_item.position == '0 ||
                           in_item.position > count_r + 1'b1) begin
                out_nxt.status = pli_pkg::ST_BADPOS;
              end else begin
                out_nxt.status = pli_pkg::ST_OK;
                ctl.op         = pli_pkg::CELL_INSERT;
                count_nxt      = count_r + 1'b1;
              end
              out_nxt.entry_count = count_nxt;
            end
            pli_pkg::ACT_DELETE: begin
              out_valid_nxt = 1'b1;
              priority if (count_r == '0) begin
                out_nxt.status = pli_pkg::ST_EMPTY;
              end else if (in_item.position == '0 || in_item.position > count_r) begin
                out_nxt.status = pli_pkg::ST_BADPOS;
              end else begin
                out_nxt.status = pli_pkg::ST_OK;
                ctl.op         = pli_pkg::CELL_DELETE;
                count_nxt      = count_r - 1'b1;
              end
              out_nxt.entry_count = count_nxt;
            end
            pli_pkg::ACT_READ: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = pli_pkg::ST_EMPTY;
              end else begin
                state_nxt  = S_READ;
                rd_idx_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        // head cell holds entry rd_idx_r while the chain rotates
        ctl.op              = pli_pkg::CELL_ROTATE;
        out_valid_nxt       = 1'b1;
        out_nxt.status      = pli_pkg::ST_OK;
        out_nxt.entry_value = cell_val[0];
        out_nxt.entry_index = rd_idx_r;
        out_nxt.entry_count = count_r;
        out_nxt.last        = rd_last;
        rd_idx_nxt          = rd_idx_r + 1'b1;
        if (rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [pli_pkg::VAL_W-1:0] left_v;
    logic signed [pli_pkg::VAL_W-1:0] right_v;

    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end

    if (g == DEPTH - 1) begin : g_end
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end

    pli_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cell_idx  (pli_pkg::CNT_W'(g)),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (cell_val[0]),
      .value     (cell_val[g])
    );
  end

  assign busy       = (state_r == S_READ);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

@@ tb/sv/positional_list_insert_delete_tb.sv @@
// testbench for positional_list_insert_delete: directed table, then random words
// checked against a behavioral list predictor; depends on pli_pkg and the rtl
`timescale 1ns / 100ps

module positional_list_insert_delete_tb;

  localparam int DEPTH = 64;
  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_WORDS = 460;
  localparam int PHASE_WORDS = 60;
  localparam int DRAIN_CYCLES = 10;

  // one row of the directed table; typed rows carry their expected status word
  typedef struct packed {
    pli_pkg::action_t          act;
    logic [pli_pkg::CNT_W-1:0] pos;
    logic [pli_pkg::VAL_W-1:0] val;
    logic                      typed;
    pli_pkg::status_t          st;
    logic [pli_pkg::CNT_W-1:0] cnt;
  } plan_row_t;

  localparam int PLAN_ROWS = 24;
  localparam plan_row_t DIRECTED [0:PLAN_ROWS-1] = '{
    '{pli_pkg::ACT_READ,   7'd0,   32'h0000_0000, 1'b1, pli_pkg::ST_EMPTY,  7'd0},
    '{pli_pkg::ACT_DELETE, 7'd1,   32'h0000_0000, 1'b1, pli_pkg::ST_EMPTY,  7'd0},
    '{pli_pkg::ACT_INSERT, 7'd0,   32'h1234_5678, 1'b1, pli_pkg::ST_BADPOS, 7'd0},
    '{pli_pkg::ACT_INSERT, 7'd2,   32'h0000_0000, 1'b1, pli_pkg::ST_BADPOS, 7'd0},
    '{pli_pkg::ACT_NONE,   7'd0,   32'h0000_0000, 1'b1, pli_pkg::ST_OK,     7'd0},
    '{pli_pkg::ACT_INSERT, 7'd1,   32'h7fff_ffff, 1'b1, pli_pkg::ST_OK,     7'd1},
    '{pli_pkg::ACT_INSERT, 7'd1,   32'h8000_0000, 1'b1, pli_pkg::ST_OK,     7'd2},
    '{pli_pkg::ACT_INSERT, 7'd3,   32'hffff_ffff, 1'b1, pli_pkg::ST_OK,     7'd3},
    '{pli_pkg::ACT_INSERT, 7'd2,   32'h0000_0000, 1'b1, pli_pkg::ST_OK,     7'd4},
    '{pli_pkg::ACT_READ,   7'd0,   32'h0000_0000, 1'b0, pli_pkg::ST_OK,     7'd0},
    '{pli_pkg::ACT_DELETE, 7'd0,   32'h0000_0000, 1'b1, pli_pkg::ST_BADPOS, 7'd4},
    '{pli_pkg::ACT_DELETE, 7'd5,   32'h0000_0000, 1'b1, pli_pkg::ST_BADPOS, 7'd4},
    '{pli_pkg::ACT_INSERT, 7'd6,   32'h0000_0000, 1'b1, pli_pkg::ST_BADPOS, 7'd4},
    '{pli_pkg::ACT_INSERT, 7'd127, 32'h5555_aaaa, 1'b1, pli_pkg::ST_BADPOS, 7'd4},
    '{pli_pkg::ACT_DELETE, 7'd64,  32'h0000_0000, 1'b1, pli_pkg::ST_BADPOS, 7'd4},
    '{pli_pkg::ACT_DELETE, 7'd1,   32'h0000_0000, 1'b1, pli_pkg::ST_OK,     7'd3},
    '{pli_pkg::ACT_DELETE, 7'd3,   32'h0000_0000, 1'b1, pli_pkg::ST_OK,     7'd2},
    '{pli_pkg::ACT_READ,   7'd0,   32'h0000_0000, 1'b0, pli_pkg::ST_OK,     7'd0},
    '{pli_pkg::ACT_INSERT, 7'd2,   32'haaaa_5555, 1'b0, pli_pkg::ST_OK,     7'd0},
    '{pli_pkg::ACT_INSERT, 7'd4,   32'h0000_0001, 1'b0, pli_pkg::ST_OK,     7'd0},
    '{pli_pkg::ACT_DELETE, 7'd2,   32'h0000_0000, 1'b0, pli_pkg::ST_OK,     7'd0},
    '{pli_pkg::ACT_READ,   7'd0,   32'h0000_0000, 1'b0, pli_pkg::ST_OK,     7'd0},
    '{pli_pkg::ACT_NONE,   7'd127, 32'hffff_ffff, 1'b1, pli_pkg::ST_OK,     7'd0},
    '{pli_pkg::ACT_READ,   7'd0,   32'h0000_0000, 1'b0, pli_pkg::ST_OK,     7'd0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  pli_pkg::in_word_t  in_item = '0;
  logic               out_valid;
  pli_pkg::out_word_t out_result;

  // predictor state
  logic signed [pli_pkg::VAL_W-1:0] list_model [DEPTH];
  int                               held_count;
  bit                               filling;
  pli_pkg::out_word_t               pending_words [$];

  int error_count;
  int results_seen;
  int n_insert, n_delete, n_read, n_ignored;
  int n_full, n_empty, n_badpos, peak_count;

  positional_list_insert_delete #(.DEPTH(DEPTH)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic pli_pkg::out_word_t make_word(input pli_pkg::status_t st,
                                                   input logic [pli_pkg::VAL_W-1:0] v,
                                                   input int idx, input int cnt,
                                                   input logic lst);
    pli_pkg::out_word_t w;
    w = '0;
    w.status      = st;
    w.entry_value = v;
    w.entry_index = pli_pkg::IDX_W'(idx);
    w.entry_count = pli_pkg::CNT_W'(cnt);
    w.last        = lst;
    return w;
  endfunction

  // applies one word to the list model and returns the words it should produce
  task automatic predict_list_op(input pli_pkg::in_word_t w,
                                 output pli_pkg::out_word_t words [$]);
    int               pos;
    pli_pkg::status_t st;
    words = {};
    pos = int'(w.position);
    case (pli_pkg::action_t'(w.action))
      pli_pkg::ACT_INSERT: begin
        if (held_count >= DEPTH) st = pli_pkg::ST_FULL;
        else if (pos == 0 || pos > held_count + 1) st = pli_pkg::ST_BADPOS;
        else begin
          for (int i = held_count; i >= pos; i--) list_model[i] = list_model[i-1];
          list_model[pos-1] = w.item_value;
          held_count++;
          st = pli_pkg::ST_OK;
        end
        words.push_back(make_word(st, '0, 0, held_count, 1'b1));
      end
      pli_pkg::ACT_DELETE: begin
        if (held_count == 0) st = pli_pkg::ST_EMPTY;
        else if (pos == 0 || pos > held_count) st = pli_pkg::ST_BADPOS;
        else begin
          for (int i = pos - 1; i + 1 < held_count; i++) list_model[i] = list_model[i+1];
          held_count--;
          st = pli_pkg::ST_OK;
        end
        words.push_back(make_word(st, '0, 0, held_count, 1'b1));
      end
      pli_pkg::ACT_READ: begin
        if (held_count == 0) words.push_back(make_word(pli_pkg::ST_EMPTY, '0, 0, 0, 1'b1));
        else
          for (int i = 0; i < held_count; i++)
            words.push_back(make_word(pli_pkg::ST_OK, list_model[i], i, held_count,
                                      i + 1 == held_count));
      end
      default: ;
    endcase
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input pli_pkg::in_word_t w, input logic typed,
                           input pli_pkg::status_t t_st,
                           input logic [pli_pkg::CNT_W-1:0] t_cnt, input int idle_pct);
    pli_pkg::out_word_t words [$];
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      in_item <= pli_pkg::in_word_t'({$urandom, $urandom});
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (busy !== 1'b0);
    predict_list_op(w, words);
    if (typed) begin
      words = {};
      if (w.action != pli_pkg::ACT_NONE) words.push_back(make_word(t_st, '0, 0, t_cnt, 1'b1));
    end
    foreach (words[i]) begin
      pending_words.push_back(words[i]);
      if (words[i].status == pli_pkg::ST_FULL) n_full++;
      if (words[i].status == pli_pkg::ST_EMPTY) n_empty++;
      if (words[i].status == pli_pkg::ST_BADPOS) n_badpos++;
    end
    case (pli_pkg::action_t'(w.action))
      pli_pkg::ACT_INSERT: n_insert++;
      pli_pkg::ACT_DELETE: n_delete++;
      pli_pkg::ACT_READ:   n_read++;
      default:             n_ignored++;
    endcase
    if (held_count > peak_count) peak_count = held_count;
    @(negedge clk);
  endtask

  function automatic logic [pli_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(1) ? 32'hffff_ffff : 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // mostly sweeps the list up to full and back down to empty, with some noise
  function automatic pli_pkg::in_word_t pick_word();
    pli_pkg::in_word_t w;
    int                roll;
    pli_pkg::action_t  op;
    w = '0;
    w.item_value = pick_value();
    roll = $urandom_range(99);
    if (roll < 6) begin
      w.action   = 2'($urandom_range(3));
      w.position = pli_pkg::CNT_W'($urandom_range(127));
    end else if (roll < 14) begin
      w.action = pli_pkg::ACT_READ;
    end else begin
      if ($urandom_range(99) < 85) op = filling ? pli_pkg::ACT_INSERT : pli_pkg::ACT_DELETE;
      else op = filling ? pli_pkg::ACT_DELETE : pli_pkg::ACT_INSERT;
      w.action = op;
      case ($urandom_range(3))
        0: w.position = 7'd1;
        1: w.position = pli_pkg::CNT_W'(op == pli_pkg::ACT_INSERT ? held_count + 1
                                                                  : held_count);
        default: w.position = pli_pkg::CNT_W'(op == pli_pkg::ACT_INSERT
                                              ? $urandom_range(held_count + 1, 1)
                                              : $urandom_range(held_count, 1));
      endcase
    end
    return w;
  endfunction

  // sender idle chance in percent per phase; phases 1 and 3 of each four leave gaps
  function automatic int idle_for_phase(input int phase);
    case (phase % 4)
      1:       return 76;
      3:       return 15;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin : result_check
    pli_pkg::out_word_t exp_w;
    if (rst_n && out_valid !== 1'b0) begin
      results_seen++;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", out_result));
      end else begin
        exp_w = pending_words.pop_front();
        if (out_valid !== 1'b1)
          report_mismatch("out_valid unknown");
        if (out_result.status !== exp_w.status)
          report_mismatch($sformatf("status exp %0d got %0d", exp_w.status,
                                    out_result.status));
        if (out_result.entry_value !== exp_w.entry_value)
          report_mismatch($sformatf("entry_value exp %h got %h", exp_w.entry_value,
                                    out_result.entry_value));
        if (out_result.entry_index !== exp_w.entry_index)
          report_mismatch($sformatf("entry_index exp %0d got %0d", exp_w.entry_index,
                                    out_result.entry_index));
        if (out_result.entry_count !== exp_w.entry_count)
          report_mismatch($sformatf("entry_count exp %0d got %0d", exp_w.entry_count,
                                    out_result.entry_count));
        if (out_result.last !== exp_w.last)
          report_mismatch($sformatf("last exp %0d got %0d", exp_w.last, out_result.last));
      end
    end
  end

  initial begin : stimulus
    pli_pkg::in_word_t w;
    int                sent;
    int                phase;
    held_count = 0;
    filling    = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      w = '0;
      w.action     = DIRECTED[i].act;
      w.position   = DIRECTED[i].pos;
      w.item_value = DIRECTED[i].val;
      send_word(w, DIRECTED[i].typed, DIRECTED[i].st, DIRECTED[i].cnt, 0);
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent / PHASE_WORDS != phase) begin
        phase = sent / PHASE_WORDS;
        // let the block run dry between phases
        start <= 1'b0;
        @(negedge clk);
        while (pending_words.size() != 0) @(negedge clk);
      end
      if (filling && held_count == DEPTH && $urandom_range(2) == 0) filling = 1'b0;
      if (!filling && held_count == 0 && $urandom_range(2) == 0) filling = 1'b1;
      w = pick_word();
      send_word(w, 1'b0, pli_pkg::ST_OK, '0, idle_for_phase(phase));
      if (w.action != pli_pkg::ACT_NONE) sent++;
    end

    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d inserts, %0d deletes, %0d read-outs, %0d ignored words, %0d results",
             n_insert, n_delete, n_read, n_ignored, results_seen);
    $display("rejections: %0d full, %0d empty, %0d bad position; deepest list %0d entries",
             n_full, n_empty, n_badpos, peak_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ positional_list_insert_delete.f @@
src/pli_pkg.sv
src/pli_cell.sv
src/positional_list_insert_delete.sv
tb/sv/positional_list_insert_delete_tb.sv
